/* hw/rtl/nkm_pkg.sv */
// Shared types and constants of the nearest-key match pool.
// Used by nkm_cell, nkm_mod and nearest_key_match_pool; depends on nothing.
package nkm_pkg;

    localparam int Capacity  = 1024;
    localparam int KeyBits   = 31;
    localparam int CountBits = $clog2(Capacity + 1);
    localparam int TotalMod  = 1000000;
    localparam int TotalBits = 20;
    // The modulo unit multiplies by the reciprocal of TotalMod, scaled by 2^ModShift and
    // rounded up. The rounding error is below 2^20, so times any key it stays below
    // 2^ModShift and the quotient is exact.
    localparam int ModShift  = KeyBits + 20;
    localparam int RecipBits = KeyBits + 1;
    localparam int ProdBits  = KeyBits + RecipBits;
    localparam int QuotBits  = (KeyBits > 20) ? KeyBits - 19 : 1;
    localparam logic [63:0] ModRecip =
        ((64'd1 << ModShift) + 64'(TotalMod) - 64'd1) / 64'(TotalMod);
    localparam int GroupSize = 32;
    localparam int Groups    = (Capacity + GroupSize - 1) / GroupSize;

    typedef logic [KeyBits-1:0] key_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_FIND,
        CELL_REMOVE
    } cell_op_t;

    // What one cell shows its neighbors. head is set only on the tie-off left of cell 0.
    typedef struct packed {
        logic head;
        logic valid;
        key_t key;
        logic lt;
        logic gtx;
        logic gtp;
        key_t gap;
    } cell_out_t;

endpackage

/* hw/rtl/nkm_cell.sv */
// One slot of the sorted key chain: holds a key and its valid bit.
// Depends on nkm_pkg for the key type, the command codes and the neighbor struct.
module nkm_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  nkm_pkg::cell_op_t  cmd,
    input  nkm_pkg::key_t      x,
    input  nkm_pkg::key_t      p,
    input  nkm_pkg::cell_out_t prv,
    input  nkm_pkg::cell_out_t nxt,
    output nkm_pkg::cell_out_t self_out,
    output nkm_pkg::key_t      sel_key
);

    nkm_pkg::key_t key_reg;
    logic          valid_reg;
    nkm_pkg::key_t sel_reg;

    logic          lt;
    logic          gtx;
    logic          gtp;
    nkm_pkg::key_t gap;
    logic          pick_low;
    logic          pick_high;
    logic          rm_shift;

    always_comb begin
        lt   = valid_reg && (key_reg < x);
        gtx  = valid_reg && (key_reg > x);
        gtp  = valid_reg && (key_reg > p);
        gap  = (key_reg < x) ? (x - key_reg) : (key_reg - x);
        // Last key below x: wins unless the right neighbor is closer or exact.
        pick_low = lt && (!nxt.valid ||
                   (!nxt.lt && (nxt.gap != '0) && (gap <= nxt.gap)));
        // First key at or above x: wins when exact or strictly closer than the left one.
        pick_high = valid_reg && !lt && (!prv.valid ||
                    (prv.lt && ((gap == '0) || (gap < prv.gap))));
        // Removal takes out the last copy of p; everything above it moves left.
        rm_shift = valid_reg && (gtp ||
                   ((key_reg == p) && !(nxt.valid && !nxt.gtp)));
    end

    always_comb begin
        self_out       = '0;
        self_out.valid = valid_reg;
        self_out.key   = key_reg;
        self_out.lt    = lt;
        self_out.gtx   = gtx;
        self_out.gtp   = gtp;
        self_out.gap   = gap;
    end

    assign sel_key = sel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            case (cmd)
                nkm_pkg::CELL_INSERT: begin
                    if (prv.valid && prv.gtx) begin
                        valid_reg <= 1'b1;
                    end else if ((!valid_reg || gtx) &&
                                 (prv.head || (prv.valid && !prv.gtx))) begin
                        valid_reg <= 1'b1;
                    end
                end
                nkm_pkg::CELL_REMOVE: begin
                    if (rm_shift) begin
                        valid_reg <= nxt.valid;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            nkm_pkg::CELL_INSERT: begin
                if (prv.valid && prv.gtx) begin
                    key_reg <= prv.key;
                end else if ((!valid_reg || gtx) &&
                             (prv.head || (prv.valid && !prv.gtx))) begin
                    key_reg <= x;
                end
            end
            nkm_pkg::CELL_FIND: begin
                sel_reg <= (pick_low || pick_high) ? key_reg : '0;
            end
            nkm_pkg::CELL_REMOVE: begin
                if (rm_shift) begin
                    key_reg <= nxt.key;
                end
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/nkm_mod.sv */
// Remainder of a match cost modulo the total's modulus by reciprocal multiplication:
// the quotient is registered first, then the remainder. Depends on nkm_pkg.
module nkm_mod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  nkm_pkg::key_t                 value,
    output logic                          done,
    output logic [nkm_pkg::TotalBits-1:0] rem
);

    logic [nkm_pkg::ProdBits-1:0]  prod;
    nkm_pkg::key_t                 val_reg;
    logic [nkm_pkg::QuotBits-1:0]  quot_reg;
    nkm_pkg::key_t                 quot_scaled;
    logic [nkm_pkg::TotalBits-1:0] rem_reg;
    logic                          busy_reg;
    logic                          done_reg;

    assign prod = nkm_pkg::ProdBits'(value) * nkm_pkg::ProdBits'(nkm_pkg::ModRecip);
    assign quot_scaled = nkm_pkg::key_t'(quot_reg) * nkm_pkg::key_t'(nkm_pkg::TotalMod);
    assign done = done_reg;
    assign rem  = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= value;
            quot_reg <= prod[nkm_pkg::ModShift +: nkm_pkg::QuotBits];
        end
        if (busy_reg) begin
            rem_reg <= nkm_pkg::TotalBits'(val_reg - quot_scaled);
        end
    end

endmodule

/* hw/rtl/nearest_key_match_pool.sv */
// Nearest-key match pool: a sorted chain of key cells with a nearest-neighbor remove.
// A dropped insert goes straight to its output beat, an insert first writes the chain, and a
// match passes the chain search, a two-level registered partner select, the removal and the
// reciprocal-multiply modulo unit. One item is in work at a time; the next beat is taken the
// cycle after the result is loaded, and a result held back by m_tready holds the input too.
// Reset (aresetn low, synchronous) empties the pool and clears the kind and running total.
module nearest_key_match_pool (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [30:0] key_value, [31] zero fill
    input  logic         s_tuser,   // [0] kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,   // [30:0] partner_value, [61:31] match_cost,
                                    // [81:62] running_total, [87:82] zero fill
    output logic [1:0]   m_tuser    // [0] matched, [1] dropped
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_FIND,
        S_SEL1,
        S_SEL2,
        S_REMOVE,
        S_MOD,
        S_DONE
    } state_t;

    state_t                         state_reg;
    logic [nkm_pkg::CountBits-1:0]  count_reg;
    logic                           pool_kind_reg;
    logic [nkm_pkg::TotalBits-1:0]  total_reg;
    nkm_pkg::key_t                  x_reg;
    nkm_pkg::key_t                  p_reg;
    nkm_pkg::key_t                  cost_reg;
    logic                           res_matched_reg;
    logic                           res_dropped_reg;
    nkm_pkg::key_t                  grp_reg [nkm_pkg::Groups];
    nkm_pkg::key_t                  grp_next [nkm_pkg::Groups];
    nkm_pkg::key_t                  p_next;

    logic                           m_valid_reg;
    logic [87:0]                    m_data_reg;
    logic [1:0]                     m_user_reg;

    nkm_pkg::cell_op_t              cmd;
    nkm_pkg::cell_out_t             co [nkm_pkg::Capacity];
    nkm_pkg::key_t                  sel_key [nkm_pkg::Capacity];
    logic [nkm_pkg::Capacity-1:0]   valid_vec;
    nkm_pkg::cell_out_t             head_tie;
    nkm_pkg::cell_out_t             tail_tie;

    logic                           accept;
    nkm_pkg::key_t                  in_key;
    nkm_pkg::key_t                  cost_now;
    logic                           mod_done;
    logic [nkm_pkg::TotalBits-1:0]  mod_rem;
    logic [nkm_pkg::TotalBits:0]    total_sum;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign in_key   = s_tdata[nkm_pkg::KeyBits-1:0];
    assign cost_now = (p_reg > x_reg) ? (p_reg - x_reg) : (x_reg - p_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // The cell left of cell 0 is a marker that tells it to take a new key;
    // the cell right of the last one looks empty.
    always_comb begin
        head_tie      = '0;
        head_tie.head = 1'b1;
        tail_tie      = '0;
    end

    always_comb begin
        case (state_reg)
            S_INSERT: cmd = nkm_pkg::CELL_INSERT;
            S_FIND:   cmd = nkm_pkg::CELL_FIND;
            S_REMOVE: cmd = nkm_pkg::CELL_REMOVE;
            default:  cmd = nkm_pkg::CELL_HOLD;
        endcase
    end

    // The chain: each cell sees only its two neighbors.
    for (genvar i = 0; i < nkm_pkg::Capacity; i++) begin : g_cell
        nkm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .x        (x_reg),
            .p        (p_reg),
            .prv      ((i == 0) ? head_tie : co[(i == 0) ? 0 : i - 1]),
            .nxt      ((i == nkm_pkg::Capacity - 1) ? tail_tie :
                       co[(i == nkm_pkg::Capacity - 1) ? i : i + 1]),
            .self_out (co[i]),
            .sel_key  (sel_key[i])
        );
        assign valid_vec[i] = co[i].valid;
    end

    // Exactly one cell selects its key after the search and all others hold zero, so the
    // partner is an OR over the chain, done in two registered levels.
    always_comb begin
        for (int g = 0; g < nkm_pkg::Groups; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < nkm_pkg::GroupSize; j++) begin
                if (g * nkm_pkg::GroupSize + j < nkm_pkg::Capacity) begin
                    grp_next[g] = grp_next[g] | sel_key[g * nkm_pkg::GroupSize + j];
                end
            end
        end
    end

    always_comb begin
        p_next = '0;
        for (int g = 0; g < nkm_pkg::Groups; g++) begin
            p_next = p_next | grp_reg[g];
        end
    end

    nkm_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_REMOVE),
        .value   (cost_now),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    assign total_sum = {1'b0, total_reg} + {1'b0, mod_rem};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pool_kind_reg <= 1'b0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // A new beat loaded in S_DONE replaces the one leaving, so the clear is skipped there.
            if (m_valid_reg && m_tready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if ((count_reg == '0) || (s_tuser == pool_kind_reg)) begin
                            if (count_reg == nkm_pkg::CountBits'(nkm_pkg::Capacity)) begin
                                state_reg <= S_DONE;
                            end else begin
                                pool_kind_reg <= s_tuser;
                                state_reg     <= S_INSERT;
                            end
                        end else begin
                            state_reg <= S_FIND;
                        end
                    end
                end
                S_INSERT: begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_FIND:   state_reg <= S_SEL1;
                S_SEL1:   state_reg <= S_SEL2;
                S_SEL2:   state_reg <= S_REMOVE;
                S_REMOVE: begin
                    count_reg <= count_reg - 1'b1;
                    state_reg <= S_MOD;
                end
                S_MOD: begin
                    if (mod_done) begin
                        if (total_sum >= (nkm_pkg::TotalBits + 1)'(nkm_pkg::TotalMod)) begin
                            total_reg <= nkm_pkg::TotalBits'(total_sum -
                                         (nkm_pkg::TotalBits + 1)'(nkm_pkg::TotalMod));
                        end else begin
                            total_reg <= total_sum[nkm_pkg::TotalBits-1:0];
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    x_reg           <= in_key;
                    cost_reg        <= '0;
                    res_matched_reg <= 1'b0;
                    res_dropped_reg <= ((count_reg == '0) || (s_tuser == pool_kind_reg)) &&
                                       (count_reg == nkm_pkg::CountBits'(nkm_pkg::Capacity));
                end
            end
            S_SEL1: grp_reg <= grp_next;
            S_SEL2: p_reg <= p_next;
            S_REMOVE: begin
                cost_reg        <= cost_now;
                res_matched_reg <= 1'b1;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_reg <= {6'b0, total_reg, cost_reg,
                                   res_matched_reg ? p_reg : nkm_pkg::key_t'(0)};
                    m_user_reg <= {res_dropped_reg, res_matched_reg};
                end
            end
            default: ;
        endcase
    end

    // Between items the valid cells must agree with the fill count.
    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> ($countones(valid_vec) == int'(count_reg)))
        else $error("valid cells disagree with entry count");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= nkm_pkg::CountBits'(nkm_pkg::Capacity))
        else $error("entry count above capacity");

    a_match_not_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result both matched and dropped");

    a_total_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg < nkm_pkg::TotalBits'(nkm_pkg::TotalMod))
        else $error("running total out of range");

endmodule
